// ----- rtl/cba_pkg.sv -----
// Shared types and constants for the cubic Bezier arc length block.
package cba_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 52;
    localparam int SQ_W       = 50;
    localparam int T_W        = 17;
    localparam int SEG_W      = 9;
    localparam int LEN_W      = 33;
    localparam int CNT_W      = 5;
    localparam int STAGE_W    = 3;
    localparam int DIV_STEPS  = 17;
    localparam int ROOT_STEPS = 25;
    localparam int LAST_STAGE = 5;
    localparam logic [SEG_W-1:0] SEG_RESET = 9'd20;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_TSTEP,
        OP_MUL,
        OP_MIXWR,
        OP_SQMUL,
        OP_SQWR,
        OP_RINIT,
        OP_ROOT,
        OP_ACC,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [STAGE_W-1:0] stage;
        logic               axis;
    } t_cmd;

endpackage

// ----- rtl/cba_ctrl.sv -----
// Sequencer that steps the datapath through divide, interpolate, square and root.
module cba_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    input  logic [cba_pkg::SEG_W-1:0]   i_seg_n,
    output cba_pkg::t_cmd               o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_TSTEP, S_MUL, S_MIXWR, S_SQMUL, S_SQWR,
        S_RINIT, S_ROOT, S_ACC, S_DONE
    } t_state;

    t_state                       r_state, n_state;
    logic [cba_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [cba_pkg::STAGE_W-1:0]  r_stage, n_stage;
    logic                         r_axis, n_axis;
    logic [cba_pkg::SEG_W-1:0]    r_seg, n_seg;
    logic                         r_ovalid, n_ovalid;
    logic                         out_load;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    always_comb begin
        o_cmd.op    = cba_pkg::OP_NOP;
        o_cmd.stage = r_stage;
        o_cmd.axis  = r_axis;
        case (r_state)
            S_IDLE:  o_cmd.op = i_valid ? cba_pkg::OP_LOAD : cba_pkg::OP_NOP;
            S_DIV:   o_cmd.op = cba_pkg::OP_DIV;
            S_TSTEP: o_cmd.op = cba_pkg::OP_TSTEP;
            S_MUL:   o_cmd.op = cba_pkg::OP_MUL;
            S_MIXWR: o_cmd.op = cba_pkg::OP_MIXWR;
            S_SQMUL: o_cmd.op = cba_pkg::OP_SQMUL;
            S_SQWR:  o_cmd.op = cba_pkg::OP_SQWR;
            S_RINIT: o_cmd.op = cba_pkg::OP_RINIT;
            S_ROOT:  o_cmd.op = cba_pkg::OP_ROOT;
            S_ACC:   o_cmd.op = cba_pkg::OP_ACC;
            S_DONE:  o_cmd.op = out_load ? cba_pkg::OP_OUT : cba_pkg::OP_NOP;
            default: o_cmd.op = cba_pkg::OP_NOP;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_stage  = r_stage;
        n_axis   = r_axis;
        n_seg    = r_seg;
        n_ovalid = r_ovalid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cnt   = '0;
                    n_seg   = cba_pkg::SEG_W'(1);
                    n_state = (i_seg_n == '0) ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == cba_pkg::CNT_W'(cba_pkg::DIV_STEPS - 1)) begin
                    n_state = S_TSTEP;
                end
            end
            S_TSTEP: begin
                n_stage = '0;
                n_axis  = 1'b0;
                n_state = S_MUL;
            end
            S_MUL: n_state = S_MIXWR;
            S_MIXWR: begin
                if (r_stage == cba_pkg::STAGE_W'(cba_pkg::LAST_STAGE)) begin
                    n_stage = '0;
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_axis  = 1'b0;
                        n_state = S_SQMUL;
                    end
                end else begin
                    n_stage = r_stage + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_SQMUL: n_state = S_SQWR;
            S_SQWR: begin
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_SQMUL;
                end else begin
                    n_axis  = 1'b0;
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                n_cnt   = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == cba_pkg::CNT_W'(cba_pkg::ROOT_STEPS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_seg == i_seg_n) begin
                    n_state = S_DONE;
                end else begin
                    n_seg   = r_seg + 1'b1;
                    n_state = S_TSTEP;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_stage  <= '0;
            r_axis   <= 1'b0;
            r_seg    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_stage  <= n_stage;
            r_axis   <= n_axis;
            r_seg    <= n_seg;
            r_ovalid <= n_ovalid;
        end
    end

    // A finished result never overwrites one that is still stalled.
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && i_stall) |=> (r_state == S_DONE))
        else $error("result loaded over a stalled beat");

    a_root_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_cnt == cba_pkg::CNT_W'(cba_pkg::ROOT_STEPS - 1))
        |=> (r_state == S_ACC))
        else $error("square root did not finish on time");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_seg != '0 && r_seg <= i_seg_n))
        else $error("segment index out of range");

    a_tstep_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TSTEP) |=> (r_state == S_MUL && r_stage == '0 && !r_axis))
        else $error("segment did not start at the first stage");

endmodule

// ----- rtl/cba_dpath.sv -----
// Arithmetic datapath: divide, t stepping, shared multiplier, interpolation, square root, sum.
module cba_dpath (
    input  logic                                 i_clk,
    input  cba_pkg::t_cmd                        i_cmd,
    input  logic [cba_pkg::SEG_W-1:0]            i_seg_n,
    input  logic signed [cba_pkg::COORD_W-1:0]   i_pts_x [4],
    input  logic signed [cba_pkg::COORD_W-1:0]   i_pts_y [4],
    output logic [cba_pkg::LEN_W-1:0]            o_arc_length
);

    logic signed [cba_pkg::COORD_W-1:0] r_px [4];
    logic signed [cba_pkg::COORD_W-1:0] r_py [4];
    logic signed [cba_pkg::COORD_W-1:0] r_w [3];
    logic signed [cba_pkg::COORD_W-1:0] r_cx, r_cy, r_prevx, r_prevy;
    logic [cba_pkg::T_W-1:0]            r_t, r_dq;
    logic [cba_pkg::SEG_W-1:0]          r_tr;
    logic [cba_pkg::SEG_W:0]            r_drem;
    logic signed [cba_pkg::PROD_W-1:0]  r_prod;
    logic [cba_pkg::SQ_W-1:0]           r_sum, r_rem, r_root, r_bit;
    logic [cba_pkg::LEN_W-1:0]          r_total, r_arc;

    logic signed [cba_pkg::COORD_W-1:0] opa, opb, dsel;
    logic signed [cba_pkg::DIFF_W-1:0]  diff, dx, dy, dd;
    logic signed [cba_pkg::MUL_W-1:0]   ma, mb, mix_sum;
    logic signed [cba_pkg::PROD_W-1:0]  n_prod;
    logic [cba_pkg::SEG_W:0]            div_trial, tr_sum;
    logic                               div_ge, tr_ge;
    logic [cba_pkg::SQ_W-1:0]           root_trial;
    logic [cba_pkg::LEN_W:0]            acc_sum;
    logic                               is_sq;

    function automatic logic signed [cba_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic signed [cba_pkg::COORD_W-1:0] v);
        DIFF_EXT = cba_pkg::DIFF_W'(v);
    endfunction

    // Operand pair of the de Casteljau step selected by stage and axis.
    always_comb begin
        case (i_cmd.stage)
            3'd0: begin opa = i_cmd.axis ? r_py[0] : r_px[0];
                        opb = i_cmd.axis ? r_py[1] : r_px[1]; end
            3'd1: begin opa = i_cmd.axis ? r_py[1] : r_px[1];
                        opb = i_cmd.axis ? r_py[2] : r_px[2]; end
            3'd2: begin opa = i_cmd.axis ? r_py[2] : r_px[2];
                        opb = i_cmd.axis ? r_py[3] : r_px[3]; end
            3'd4: begin opa = r_w[1]; opb = r_w[2]; end
            default: begin opa = r_w[0]; opb = r_w[1]; end
        endcase
    end

    assign diff = DIFF_EXT(opb) - DIFF_EXT(opa);
    assign dx   = DIFF_EXT(r_cx) - DIFF_EXT(r_prevx);
    assign dy   = DIFF_EXT(r_cy) - DIFF_EXT(r_prevy);
    assign dd   = i_cmd.axis ? dy : dx;
    assign dsel = opa;
    assign is_sq = (i_cmd.op == cba_pkg::OP_SQMUL);
    assign ma   = is_sq ? cba_pkg::MUL_W'(dd) : cba_pkg::MUL_W'(diff);
    assign mb   = is_sq ? cba_pkg::MUL_W'(dd)
                        : $signed({{(cba_pkg::MUL_W - cba_pkg::T_W){1'b0}}, r_t});
    assign n_prod  = cba_pkg::PROD_W'(ma) * cba_pkg::PROD_W'(mb);
    // a + floor((b - a) * t / 2^16), the same as the floor of the weighted sum.
    assign mix_sum = cba_pkg::MUL_W'(dsel) + r_prod[41:16];

    assign div_trial = {r_drem[cba_pkg::SEG_W-1:0], r_dq[cba_pkg::T_W-1]};
    assign div_ge    = div_trial >= {1'b0, i_seg_n};
    assign tr_sum    = {1'b0, r_tr} + r_drem;
    assign tr_ge     = tr_sum >= {1'b0, i_seg_n};
    assign root_trial = r_root + r_bit;
    assign acc_sum   = {1'b0, r_total} + (cba_pkg::LEN_W + 1)'(r_root);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cba_pkg::OP_LOAD: begin
                r_px    <= i_pts_x;
                r_py    <= i_pts_y;
                r_prevx <= i_pts_x[0];
                r_prevy <= i_pts_y[0];
                r_t     <= '0;
                r_tr    <= '0;
                r_dq    <= cba_pkg::T_W'(1) << (cba_pkg::T_W - 1);
                r_drem  <= '0;
                r_total <= '0;
            end
            cba_pkg::OP_DIV: begin
                r_drem <= div_ge ? (div_trial - {1'b0, i_seg_n}) : div_trial;
                r_dq   <= {r_dq[cba_pkg::T_W-2:0], div_ge};
            end
            cba_pkg::OP_TSTEP: begin
                r_tr <= tr_ge ? cba_pkg::SEG_W'(tr_sum - {1'b0, i_seg_n})
                              : tr_sum[cba_pkg::SEG_W-1:0];
                r_t  <= r_t + r_dq + cba_pkg::T_W'(tr_ge);
            end
            cba_pkg::OP_MUL, cba_pkg::OP_SQMUL: r_prod <= n_prod;
            cba_pkg::OP_MIXWR: begin
                case (i_cmd.stage)
                    3'd0, 3'd3: r_w[0] <= mix_sum[cba_pkg::COORD_W-1:0];
                    3'd1, 3'd4: r_w[1] <= mix_sum[cba_pkg::COORD_W-1:0];
                    3'd2:       r_w[2] <= mix_sum[cba_pkg::COORD_W-1:0];
                    default: begin
                        if (i_cmd.axis) r_cy <= mix_sum[cba_pkg::COORD_W-1:0];
                        else            r_cx <= mix_sum[cba_pkg::COORD_W-1:0];
                    end
                endcase
            end
            cba_pkg::OP_SQWR: begin
                r_sum <= i_cmd.axis ? r_sum + r_prod[cba_pkg::SQ_W-1:0]
                                    : r_prod[cba_pkg::SQ_W-1:0];
            end
            cba_pkg::OP_RINIT: begin
                r_rem  <= r_sum;
                r_root <= '0;
                r_bit  <= cba_pkg::SQ_W'(1) << (2 * (cba_pkg::ROOT_STEPS - 1));
            end
            cba_pkg::OP_ROOT: begin
                if (r_rem >= root_trial) begin
                    r_rem  <= r_rem - root_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            cba_pkg::OP_ACC: begin
                r_total <= acc_sum[cba_pkg::LEN_W] ? '1 : acc_sum[cba_pkg::LEN_W-1:0];
                r_prevx <= r_cx;
                r_prevy <= r_cy;
            end
            cba_pkg::OP_OUT: r_arc <= r_total;
            default: ;
        endcase
    end

    assign o_arc_length = r_arc;

endmodule

// ----- rtl/cubic_bezier_arc_length.sv -----
// Top level of the cubic Bezier arc length block: config register, sequencer, datapath.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------
//  input    | in        | i_valid / o_stall  | i_start_*, i_ctrl_a_*, i_ctrl_b_*, i_end_*
//  result   | out       | o_valid / i_stall  | o_arc_length
//  config   | in        | i_cfg_we           | i_cfg_data (segment count)
//
// After acceptance the sequencer runs the 17-step divide that finds the t increment.
// Then, for each of n points, where n is the segment count clamped to MAX_SEGMENTS, it
// steps t, runs the twelve interpolations and the two squares on the single shared
// multiplier, each with a multiply and a write state, takes the one bit per cycle square
// root and adds it to the sum. Last it loads the result beat; when n is zero it goes
// straight to the load. The next curve can be taken in the cycle after the load.
// Reset is synchronous and active low; it returns the segment count to 20 and empties
// the result register. The input side stalls while a curve is in progress, and a
// finished result waits in the sequencer until the output register is free.
module cubic_bezier_arc_length #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_ctrl_a_x,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_ctrl_a_y,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_ctrl_b_x,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_ctrl_b_y,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [cba_pkg::COORD_W-1:0]  i_end_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [cba_pkg::LEN_W-1:0]           o_arc_length,
    input  logic                                i_cfg_we,
    input  logic [cba_pkg::SEG_W-1:0]           i_cfg_data
);

    // Wide enough to compare the register against any legal MAX_SEGMENTS.
    localparam int CMP_W = 13;

    logic [cba_pkg::SEG_W-1:0]          r_seg_count;
    logic [cba_pkg::SEG_W-1:0]          seg_n;
    cba_pkg::t_cmd                      cmd;
    logic signed [cba_pkg::COORD_W-1:0] pts_x [4];
    logic signed [cba_pkg::COORD_W-1:0] pts_y [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= cba_pkg::SEG_RESET;
        end else if (i_cfg_we) begin
            r_seg_count <= i_cfg_data;
        end
    end

    // The register keeps what was written; counts above the limit run at the limit.
    // When the limit is below the register value it fits in the register width.
    assign seg_n = (CMP_W'(r_seg_count) > CMP_W'(MAX_SEGMENTS))
                 ? cba_pkg::SEG_W'(MAX_SEGMENTS) : r_seg_count;

    assign pts_x[0] = i_start_x;
    assign pts_x[1] = i_ctrl_a_x;
    assign pts_x[2] = i_ctrl_b_x;
    assign pts_x[3] = i_end_x;
    assign pts_y[0] = i_start_y;
    assign pts_y[1] = i_ctrl_a_y;
    assign pts_y[2] = i_ctrl_b_y;
    assign pts_y[3] = i_end_y;

    cba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_seg_n (seg_n),
        .o_cmd   (cmd)
    );

    cba_dpath u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_seg_n      (seg_n),
        .i_pts_x      (pts_x),
        .i_pts_y      (pts_y),
        .o_arc_length (o_arc_length)
    );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the cubic Bezier arc length block.
`timescale 1ns / 1ps

module testbench;

    localparam int          CURVE_PTS   = 8;
    localparam int          SEG_LIMIT   = 256;
    localparam longint      CYCLE_LIMIT = 20000000;
    localparam int          RAND_CURVES = 1950;
    localparam int          REPORT_MAX  = 10;
    localparam logic [23:0] C_MIN       = 24'h800000;
    localparam logic [23:0] C_MAX       = 24'h7FFFFF;
    localparam logic [23:0] C_NEG1      = 24'hFFFFFF;

    // One directed row: segment count, the eight coordinates in port order
    // (start, first control, second control, end; x before y), and an
    // optional hand-computed length.
    typedef struct {
        int                            seg;
        logic [0:CURVE_PTS-1][23:0]    pts;
        bit                            known;
        logic [cba_pkg::LEN_W-1:0]     len;
    } t_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic signed [cba_pkg::COORD_W-1:0]  i_start_x, i_start_y, i_ctrl_a_x, i_ctrl_a_y;
    logic signed [cba_pkg::COORD_W-1:0]  i_ctrl_b_x, i_ctrl_b_y, i_end_x, i_end_y;
    logic                                o_valid;
    logic                                i_stall;
    logic [cba_pkg::LEN_W-1:0]           o_arc_length;
    logic                                i_cfg_we;
    logic [cba_pkg::SEG_W-1:0]           i_cfg_data;

    cubic_bezier_arc_length uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_ctrl_a_x   (i_ctrl_a_x),
        .i_ctrl_a_y   (i_ctrl_a_y),
        .i_ctrl_b_x   (i_ctrl_b_x),
        .i_ctrl_b_y   (i_ctrl_b_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_arc_length (o_arc_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    // Mirror of the segment count register and the lengths still owed.
    logic [cba_pkg::SEG_W-1:0]  seg_count;
    logic [cba_pkg::LEN_W-1:0]  lengths_due[$];
    t_row                       dir_rows[$];
    int                         mismatches;
    int                         unexpected;
    int                         curves_sent;
    int                         lengths_seen;
    int                         stall_left;
    bit                         quiet;
    longint                     cycles;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Linear interpolation between a and b at t (Q1.16), floored toward
    // minus infinity by the arithmetic shift.
    function automatic longint lerp_q16(longint a, longint b, longint t);
        longint s;
        s = a * (64'sd65536 - t) + b * t;
        return s >>> 16;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Polyline length of the curve for a given segment count, walking t in
    // equal steps and summing the truncated chord lengths.
    function automatic logic [cba_pkg::LEN_W-1:0] polyline_length(
        logic [0:CURVE_PTS-1][23:0] pts, logic [cba_pkg::SEG_W-1:0] seg);
        longint px[4];
        longint py[4];
        longint n, t, ax, ay, bx, by, cx, cy, dx, dy, ex, ey, qx, qy;
        longint prev_x, prev_y, ddx, ddy;
        longint unsigned total;
        for (int k = 0; k < 4; k++) begin
            px[k] = longint'(signed'(pts[2*k]));
            py[k] = longint'(signed'(pts[2*k+1]));
        end
        n = (seg > SEG_LIMIT) ? SEG_LIMIT : longint'(seg);
        total = 0;
        prev_x = px[0];
        prev_y = py[0];
        for (longint i = 1; i <= n; i++) begin
            t  = (i << 16) / n;
            ax = lerp_q16(px[0], px[1], t);
            ay = lerp_q16(py[0], py[1], t);
            bx = lerp_q16(px[1], px[2], t);
            by = lerp_q16(py[1], py[2], t);
            cx = lerp_q16(px[2], px[3], t);
            cy = lerp_q16(py[2], py[3], t);
            dx = lerp_q16(ax, bx, t);
            dy = lerp_q16(ay, by, t);
            ex = lerp_q16(bx, cx, t);
            ey = lerp_q16(by, cy, t);
            qx = lerp_q16(dx, ex, t);
            qy = lerp_q16(dy, ey, t);
            ddx = qx - prev_x;
            ddy = qy - prev_y;
            total = total + int_sqrt(longint'(ddx * ddx) + longint'(ddy * ddy));
            if (total > 64'h1FFFFFFFF) total = 64'h1FFFFFFFF;
            prev_x = qx;
            prev_y = qy;
        end
        return total[cba_pkg::LEN_W-1:0];
    endfunction

    // Present one curve after a random gap and hold it until the block takes
    // it. The valid line is left high on return so that a back-to-back beat
    // never sees it dropped and raised within one step.
    task automatic send_curve(logic [0:CURVE_PTS-1][23:0] pts,
                              bit known, logic [cba_pkg::LEN_W-1:0] len);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_start_x  <= pts[0];
        i_start_y  <= pts[1];
        i_ctrl_a_x <= pts[2];
        i_ctrl_a_y <= pts[3];
        i_ctrl_b_x <= pts[4];
        i_ctrl_b_y <= pts[5];
        i_end_x    <= pts[6];
        i_end_y    <= pts[7];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // The beat was taken at this edge, with the count now in force.
        lengths_due.push_back(known ? len : polyline_length(pts, seg_count));
        curves_sent++;
    endtask

    // The count is only changed with the block idle: every owed length
    // delivered, then an extra wait for the output register to settle.
    task automatic set_segments(logic [cba_pkg::SEG_W-1:0] seg);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (lengths_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= seg;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        seg_count  = seg;
    endtask

    function automatic logic [23:0] rand_coord(int kind);
        logic [23:0] pick[4];
        pick = '{C_MIN, C_MAX, 24'd0, C_NEG1};
        if (kind < 60) return 24'($urandom);
        if (kind < 80) return 24'($urandom_range(0, 8191) - 4096);
        return pick[$urandom_range(0, 3)];
    endfunction

    // Result side: compare each delivered length with the oldest one owed,
    // and draw a fresh random stall after every beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                lengths_seen++;
                if (lengths_due.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= REPORT_MAX)
                        $display("unexpected result beat: length %0d", o_arc_length);
                end else begin
                    logic [cba_pkg::LEN_W-1:0] want;
                    want = lengths_due.pop_front();
                    if (o_arc_length !== want) begin
                        mismatches++;
                        if (mismatches + unexpected <= REPORT_MAX)
                            $display("arc_length mismatch: expected %0d, got %0d",
                                     want, o_arc_length);
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lengths owed", cycles,
                     lengths_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [0:CURVE_PTS-1][23:0] pts;
        int r, seg, burst, kind;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_start_x  = '0;
        i_start_y  = '0;
        i_ctrl_a_x = '0;
        i_ctrl_a_y = '0;
        i_ctrl_b_x = '0;
        i_ctrl_b_y = '0;
        i_end_x    = '0;
        i_end_y    = '0;
        seg_count  = cba_pkg::SEG_RESET;
        mismatches = 0;
        unexpected = 0;
        curves_sent = 0;
        lengths_seen = 0;
        quiet      = 1'b0;
        cycles     = 0;

        // Directed rows. A row whose count differs from the one in force
        // triggers a register write first, so the count walks through the
        // reset value, one, zero, the maximum, a value past the clamp, two and three.
        dir_rows.push_back('{20, '0, 1'b1, 33'd0});
        dir_rows.push_back('{20, {8{C_MIN}}, 1'b1, 33'd0});
        dir_rows.push_back('{20, {8{C_MAX}}, 1'b1, 33'd0});
        // A single segment is just the chord from start to end: a 3-4-5
        // triangle scaled by 256.
        dir_rows.push_back('{1, {24'd1024, 24'd768, 144'd0}, 1'b1, 33'd1280});
        dir_rows.push_back('{1, {C_MAX, C_MAX, 96'd0, C_MIN, C_MIN}, 1'b0, 33'd0});
        // Zigzag through opposite corners of the coordinate range.
        dir_rows.push_back('{20, {C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                  C_MIN, C_MIN}, 1'b0, 33'd0});
        // Zero segments always yield zero, whatever the curve.
        dir_rows.push_back('{0, {C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                 C_MIN, C_MIN}, 1'b1, 33'd0});
        dir_rows.push_back('{0, {24'h123456, 24'hABCDEF, 24'h000FFF, 24'hFFF000,
                                 24'h5A5A5A, 24'hA5A5A5, 24'h7F0000, 24'h80FFFF},
                             1'b1, 33'd0});
        dir_rows.push_back('{256, {C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                   C_MIN, C_MIN}, 1'b0, 33'd0});
        // Counts above the maximum are clamped but kept in the register.
        dir_rows.push_back('{511, {C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX,
                                   C_MIN, C_MAX}, 1'b0, 33'd0});
        dir_rows.push_back('{511, {24'd300, 24'd200, 24'd5000, 24'hFFF000,
                                   24'd100, 24'd4000, 24'd0, 24'd0}, 1'b0, 33'd0});
        dir_rows.push_back('{2, {24'hFFFF00, 24'hFFF800, 24'h000800, 24'hFFE000,
                                 24'h002000, 24'h001000, 24'hFFFC00, 24'hFFFE00},
                             1'b0, 33'd0});
        dir_rows.push_back('{3, {C_NEG1, C_NEG1, 24'd0, C_NEG1, C_NEG1, 24'd0,
                                 24'd1, 24'd1}, 1'b0, 33'd0});
        dir_rows.push_back('{3, {C_MIN, 24'd0, C_MAX, 24'd0, 24'd0, C_MIN,
                                 24'd0, C_MAX}, 1'b0, 33'd0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].seg != seg_count)
                set_segments(cba_pkg::SEG_W'(dir_rows[i].seg));
            send_curve(dir_rows[i].pts, dir_rows[i].known, dir_rows[i].len);
        end

        // Random phases. Most use short counts so the run stays fast; the
        // maximum and the clamped value get only a couple of curves each.
        while (curves_sent < RAND_CURVES + dir_rows.size()) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                seg = 0;
                burst = 20;
            end else if (r < 8) begin
                seg = ($urandom_range(0, 1) != 0) ? 256 : $urandom_range(257, 511);
                burst = 2;
            end else if (r < 20) begin
                seg = $urandom_range(13, 40);
                burst = 10;
            end else begin
                seg = $urandom_range(1, 12);
                burst = 30;
            end
            set_segments(cba_pkg::SEG_W'(seg));
            quiet = ($urandom_range(0, 4) == 0);
            repeat (burst) begin
                kind = $urandom_range(0, 99);
                if (kind < 90) begin
                    for (int k = 0; k < CURVE_PTS; k++) pts[k] = rand_coord(kind);
                end else begin
                    // Every point the same: a curve of length zero.
                    pts[0] = 24'($urandom);
                    pts[1] = 24'($urandom);
                    for (int k = 2; k < CURVE_PTS; k++) pts[k] = pts[k % 2];
                end
                send_curve(pts, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (lengths_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d curves sent, %0d lengths checked, over %0d cycles",
                 curves_sent, lengths_seen, cycles);
        $display("%0d mismatches, %0d unexpected beats, %0d still owed",
                 mismatches, unexpected, lengths_due.size());
        if (mismatches == 0 && unexpected == 0 && lengths_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
